>>> design/rwu_pkg.sv
// rwu_pkg: shared widths, register indexes, reset values and side-band struct
// for the rmsprop weight update pipeline
// no dependencies
package rwu_pkg;

  // field widths (sized for a 32-bit Q8.24 datapath)
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int DECAY_W    = 16;
  localparam int CFG_W      = 32;
  localparam int CLIP_W     = 31;
  localparam int IDX_W      = 3;

  // internal widths
  localparam int PROD_W    = 2 * DATA_WIDTH;
  localparam int SQ_W      = 2 * DATA_WIDTH - FRAC_BITS;
  localparam int DCOMP_W   = DECAY_W + 1;
  localparam int AD_W      = DATA_WIDTH + DECAY_W;
  localparam int ACC_W     = SQ_W + DCOMP_W;
  localparam int ANEW_W    = ACC_W - DECAY_W;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int NUM_W     = CFG_W + CLIP_W;
  localparam int DEN_SHIFT = 8;
  localparam int DEN_W     = ROOT_W + DEN_SHIFT;
  localparam int N_W       = 64;
  localparam int Q_W       = 44;
  localparam int WN_W      = Q_W + 3;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DECAY  = 3'd0,
    REG_LR     = 3'd1,
    REG_EPS    = 3'd2,
    REG_CLIP   = 3'd3,
    REG_WDECAY = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [DECAY_W-1:0] DECAY_RST  = 16'd65470;
  localparam logic [CFG_W-1:0]   LR_RST     = 32'd429497;
  localparam logic [CFG_W-1:0]   EPS_RST    = 32'd1;
  localparam logic [CLIP_W-1:0]  CLIP_RST   = 31'd83886080;
  localparam logic [CFG_W-1:0]   WDECAY_RST = 32'd43;

  // per-request side data carried alongside the root and divide cells
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] w;
    logic [DATA_WIDTH-1:0]        regm;
    logic                         wneg;
    logic                         gcneg;
    logic                         clipped;
    logic                         asat;
    logic [DATA_WIDTH-1:0]        aout;
    logic                         last;
    logic [NUM_W-1:0]             num;
    logic                         zero;
  } side_t;

endpackage

>>> design/rwu_front.sv
// rwu_front: five-stage front end - square, mean update, clip, step numerator
// and shrink; produces the root radicand and side data
// depends on rwu_pkg
module rwu_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [rwu_pkg::DATA_WIDTH-1:0] grad,
  input  logic signed [rwu_pkg::DATA_WIDTH-1:0] weight,
  input  logic [rwu_pkg::DATA_WIDTH-1:0]      avg,
  input  logic                                last,
  input  logic [rwu_pkg::DECAY_W-1:0]         decay,
  input  logic [rwu_pkg::CFG_W-1:0]           lr,
  input  logic [rwu_pkg::CFG_W-1:0]           eps,
  input  logic [rwu_pkg::CLIP_W-1:0]          clip,
  input  logic [rwu_pkg::CFG_W-1:0]           wdecay,
  output logic                                out_v,
  output logic [rwu_pkg::RAD_W-1:0]           rad,
  output rwu_pkg::side_t                      side
);
  import rwu_pkg::*;

  logic [DATA_WIDTH-1:0] gm, wm;
  logic                  clip_hit;
  logic [CLIP_W-1:0]     gcm;
  logic [DCOMP_W-1:0]    dcomp;
  logic [ANEW_W:0]       rsum;
  side_t                 side_next;

  // stage registers
  logic                  a_v, b_v, c_v, d_v;
  logic [PROD_W-1:0]     a_gsq, a_wprod;
  logic [AD_W-1:0]       a_ad, b_ad, c_ad;
  logic [CLIP_W-1:0]     a_gcm;
  logic                  a_gcneg, a_clipped, a_last;
  logic signed [DATA_WIDTH-1:0] a_w;
  logic [SQ_W-1:0]       b_sq;
  logic [ACC_W-1:0]      c_sqd;
  logic [ANEW_W-1:0]     d_anew;
  side_t                 b_side, c_side, d_side;

  // magnitudes, clipping and decay complement
  always_comb begin
    gm       = grad[DATA_WIDTH-1] ? unsigned'(-grad) : unsigned'(grad);
    wm       = weight[DATA_WIDTH-1] ? unsigned'(-weight) : unsigned'(weight);
    clip_hit = gm > DATA_WIDTH'(clip);
    gcm      = clip_hit ? clip : gm[CLIP_W-1:0];
    dcomp    = (DCOMP_W'(1) << DECAY_W) - DCOMP_W'(decay);
    rsum     = (ANEW_W+1)'(d_anew) + (ANEW_W+1)'(eps);
  end

  // saturated mean and zero-root flag added to the side data
  always_comb begin
    side_next      = d_side;
    side_next.asat = |d_anew[ANEW_W-1:DATA_WIDTH];
    side_next.aout = (|d_anew[ANEW_W-1:DATA_WIDTH]) ? '1 : d_anew[DATA_WIDTH-1:0];
    side_next.zero = rsum == '0;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      d_v   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      a_v   <= in_valid;
      b_v   <= a_v;
      c_v   <= b_v;
      d_v   <= c_v;
      out_v <= d_v;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // products of the inputs
      a_gsq     <= gm * gm;
      a_ad      <= avg * decay;
      a_wprod   <= wdecay * wm;
      a_gcm     <= gcm;
      a_gcneg   <= grad[DATA_WIDTH-1];
      a_clipped <= clip_hit;
      a_w       <= weight;
      a_last    <= last;
      // square rounding, step numerator, shrink rounding
      b_sq           <= SQ_W'((a_gsq + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      b_ad           <= a_ad;
      b_side.w       <= a_w;
      b_side.regm    <= DATA_WIDTH'((a_wprod + (PROD_W'(1) << (CFG_W - 1))) >> CFG_W);
      b_side.wneg    <= a_w[DATA_WIDTH-1];
      b_side.gcneg   <= a_gcneg;
      b_side.clipped <= a_clipped;
      b_side.asat    <= 1'b0;
      b_side.aout    <= '0;
      b_side.last    <= a_last;
      b_side.num     <= lr * a_gcm;
      b_side.zero    <= 1'b0;
      // new-gradient share of the mean
      c_sqd  <= b_sq * dcomp;
      c_ad   <= b_ad;
      c_side <= b_side;
      // mean, rounded by the decay fraction
      d_anew <= ANEW_W'((ACC_W'(c_ad) + c_sqd + (ACC_W'(1) << (DECAY_W - 1))) >> DECAY_W);
      d_side <= c_side;
      // radicand and saturated mean
      rad  <= RAD_W'({rsum, FRAC_BITS'(0)});
      side <= side_next;
    end
  end

endmodule

>>> design/rwu_sqrt_cell.sv
// rwu_sqrt_cell: one digit of the integer square root, two radicand bits a cell
// depends on rwu_pkg
module rwu_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rwu_pkg::RAD_W-1:0]   x_in,
  input  logic [rwu_pkg::SREM_W-1:0]  rem_in,
  input  logic [rwu_pkg::ROOT_W-1:0]  root_in,
  output logic [rwu_pkg::RAD_W-1:0]   x_out,
  output logic [rwu_pkg::SREM_W-1:0]  rem_out,
  output logic [rwu_pkg::ROOT_W-1:0]  root_out
);
  import rwu_pkg::*;

  logic [SREM_W-1:0] r, trial;
  logic              fits;

  // bring down the next bit pair and try the next root digit
  always_comb begin
    r     = {rem_in[SREM_W-3:0], x_in[RAD_W-1 -: 2]};
    trial = {root_in, 2'b01};
    fits  = r >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= {x_in[RAD_W-3:0], 2'b00};
      rem_out  <= fits ? r - trial : r;
      root_out <= {root_in[ROOT_W-2:0], fits};
    end
  end

endmodule

>>> design/rwu_div_cell.sv
// rwu_div_cell: one restoring-division step, one quotient bit a cell
// depends on rwu_pkg
module rwu_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rwu_pkg::Q_W-1:0]    n_in,
  input  logic [rwu_pkg::DEN_W-1:0]  rem_in,
  input  logic [rwu_pkg::DEN_W-1:0]  d_in,
  input  logic [rwu_pkg::Q_W-1:0]    q_in,
  output logic [rwu_pkg::Q_W-1:0]    n_out,
  output logic [rwu_pkg::DEN_W-1:0]  rem_out,
  output logic [rwu_pkg::DEN_W-1:0]  d_out,
  output logic [rwu_pkg::Q_W-1:0]    q_out
);
  import rwu_pkg::*;

  logic [DEN_W:0] r, diff;
  logic           fits;

  // shift in the next numerator bit and subtract when the divisor fits
  always_comb begin
    r    = {rem_in, n_in[Q_W-1]};
    diff = r - {1'b0, d_in};
    fits = r >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out   <= {n_in[Q_W-2:0], 1'b0};
      rem_out <= fits ? diff[DEN_W-1:0] : r[DEN_W-1:0];
      d_out   <= d_in;
      q_out   <= {q_in[Q_W-2:0], fits};
    end
  end

endmodule

>>> design/rmsprop_weight_update.sv
// rmsprop_weight_update: top level - configuration registers, front end,
// square-root cell row, divider cell row and output register
// depends on rwu_pkg, rwu_front, rwu_sqrt_cell, rwu_div_cell
//
// Usage
//   Input channel: in_valid / in_stall carry grad_in, weight_in, avg_in and
//   last_in; a request is taken at a clock edge with in_valid high and
//   in_stall low. Output channel: out_valid / out_stall carry weight_out,
//   avg_out, was_clipped, saturated and last_out, one result per request,
//   in order.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (decay, learning rate, smoothing, clip limit, weight decay); unknown
//   indexes are ignored. Write only while the pipeline is empty.
//   The pipeline has five front-end stages, 32 square-root cells (two
//   radicand bits each), one divisor stage, 44 divider cells (one quotient
//   bit each) and the output register. Throughput is one request a clock,
//   except while held: the whole pipeline moves as one, and while out_valid
//   is high and out_stall is high, every stage holds and in_stall is raised.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults.
module rmsprop_weight_update (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rwu_pkg::DATA_WIDTH-1:0] grad_in,
  input  logic signed [rwu_pkg::DATA_WIDTH-1:0] weight_in,
  input  logic [rwu_pkg::DATA_WIDTH-1:0]        avg_in,
  input  logic                                  last_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rwu_pkg::DATA_WIDTH-1:0] weight_out,
  output logic [rwu_pkg::DATA_WIDTH-1:0]        avg_out,
  output logic                                  was_clipped,
  output logic                                  saturated,
  output logic                                  last_out,
  input  logic                                  cfg_write,
  input  logic [rwu_pkg::IDX_W-1:0]             cfg_index,
  input  logic [rwu_pkg::CFG_W-1:0]             cfg_data
);
  import rwu_pkg::*;

  localparam int NSQ = ROOT_W;
  localparam logic signed [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                 pipe_en;
  logic [DECAY_W-1:0]   decay_rate;
  logic [CFG_W-1:0]     learning_rate, smoothing, weight_decay;
  logic [CLIP_W-1:0]    clip_limit;

  logic [RAD_W-1:0]     sx    [0:NSQ];
  logic [SREM_W-1:0]    srem  [0:NSQ];
  logic [ROOT_W-1:0]    sroot [0:NSQ];
  side_t                sside [0:NSQ];
  logic                 sv    [0:NSQ];

  logic                 f_valid;
  logic [N_W-1:0]       f_n;
  logic [DEN_W-1:0]     f_d;
  side_t                f_side;

  logic [Q_W-1:0]       dn    [0:Q_W];
  logic [DEN_W-1:0]     drem  [0:Q_W];
  logic [DEN_W-1:0]     dd    [0:Q_W];
  logic [Q_W-1:0]       dq    [0:Q_W];
  side_t                dside [0:Q_W];
  logic                 dv    [0:Q_W];

  logic [WN_W-1:0]        stepm, regm;
  logic signed [WN_W-1:0] step_s, reg_s, wn;
  logic                   sat_hi, sat_lo;

  // global advance: hold everything while a result waits on a stalled receiver
  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate    <= DECAY_RST;
      learning_rate <= LR_RST;
      smoothing     <= EPS_RST;
      clip_limit    <= CLIP_RST;
      weight_decay  <= WDECAY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DECAY:  decay_rate    <= cfg_data[DECAY_W-1:0];
        REG_LR:     learning_rate <= cfg_data;
        REG_EPS:    smoothing     <= cfg_data;
        REG_CLIP:   clip_limit    <= cfg_data[CLIP_W-1:0];
        REG_WDECAY: weight_decay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end
  rwu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (in_valid),
    .grad     (grad_in),
    .weight   (weight_in),
    .avg      (avg_in),
    .last     (last_in),
    .decay    (decay_rate),
    .lr       (learning_rate),
    .eps      (smoothing),
    .clip     (clip_limit),
    .wdecay   (weight_decay),
    .out_v    (sv[0]),
    .rad      (sx[0]),
    .side     (sside[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  // square-root cell row
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    rwu_sqrt_cell u_cell (
      .clk      (clk),
      .en       (pipe_en),
      .x_in     (sx[k]),
      .rem_in   (srem[k]),
      .root_in  (sroot[k]),
      .x_out    (sx[k+1]),
      .rem_out  (srem[k+1]),
      .root_out (sroot[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (pipe_en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        sside[k+1] <= sside[k];
      end
    end
  end

  // divisor and rounded numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (pipe_en) begin
      f_valid <= sv[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f_n    <= N_W'(sside[NSQ].num) + N_W'({sroot[NSQ], (DEN_SHIFT-1)'(0)});
      f_d    <= {sroot[NSQ], DEN_SHIFT'(0)};
      f_side <= sside[NSQ];
    end
  end

  // the quotient fits in Q_W bits, so the top numerator bits seed the remainder
  assign dn[0]    = f_n[Q_W-1:0];
  assign drem[0]  = DEN_W'(f_n[N_W-1:Q_W]);
  assign dd[0]    = f_d;
  assign dq[0]    = '0;
  assign dside[0] = f_side;
  assign dv[0]    = f_valid;

  // divider cell row
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    rwu_div_cell u_cell (
      .clk     (clk),
      .en      (pipe_en),
      .n_in    (dn[k]),
      .rem_in  (drem[k]),
      .d_in    (dd[k]),
      .q_in    (dq[k]),
      .n_out   (dn[k+1]),
      .rem_out (drem[k+1]),
      .d_out   (dd[k+1]),
      .q_out   (dq[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (pipe_en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dside[k+1] <= dside[k];
      end
    end
  end

  // new weight: w - step - shrink, then saturate
  always_comb begin
    stepm  = dside[Q_W].zero ? '0 : WN_W'(dq[Q_W]);
    regm   = WN_W'(dside[Q_W].regm);
    step_s = dside[Q_W].gcneg ? -$signed(stepm) : $signed(stepm);
    reg_s  = dside[Q_W].wneg ? -$signed(regm) : $signed(regm);
    wn     = WN_W'(dside[Q_W].w) - step_s - reg_s;
    sat_hi = !wn[WN_W-1] && (|wn[WN_W-2:DATA_WIDTH-1]);
    sat_lo = wn[WN_W-1] && !(&wn[WN_W-2:DATA_WIDTH-1]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      out_valid <= dv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      weight_out  <= sat_hi ? W_MAX : (sat_lo ? W_MIN : wn[DATA_WIDTH-1:0]);
      avg_out     <= dside[Q_W].aout;
      was_clipped <= dside[Q_W].clipped;
      saturated   <= sat_hi || sat_lo || dside[Q_W].asat;
      last_out    <= dside[Q_W].last;
    end
  end

`ifndef NO_ASSERTIONS
  // a saturated result with an unsaturated mean must have a limit weight
  a_sat_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated && (avg_out != '1) |->
      (weight_out == W_MAX) || (weight_out == W_MIN))
    else $error("saturated flag without a limit value");

  // a zero root and the zero flag travel together
  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> ((f_d == '0) == f_side.zero))
    else $error("root and zero flag out of step");

  // a held pipeline keeps its divisor stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |=> $stable(f_valid) && $stable(dv[Q_W]))
    else $error("pipeline moved while held");

  // a result only appears after the last divider cell held a request
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dv[Q_W]))
    else $error("result without a request in the divider row");
`endif

endmodule

>>> tb/rmsprop_weight_update_test.sv
// rmsprop_weight_update_test: self-checking bench for the rmsprop weight update
// pipeline; drives requests and register writes, predicts each result in-line
// depends on rwu_pkg and rmsprop_weight_update
`timescale 1ns / 100ps

module rmsprop_weight_update_test;
  import rwu_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_WAIT = 120;
  localparam int HOLD_LEN = 400;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] grad;
    logic signed [DATA_WIDTH-1:0] weight;
    logic [DATA_WIDTH-1:0]        avg;
    logic                         last;
  } req_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] weight;
    logic [DATA_WIDTH-1:0]        avg;
    logic                         clipped;
    logic                         sat;
    logic                         last;
  } upd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_WIDTH-1:0] grad_in = '0;
  logic signed [DATA_WIDTH-1:0] weight_in = '0;
  logic [DATA_WIDTH-1:0] avg_in = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0] weight_out;
  logic [DATA_WIDTH-1:0] avg_out;
  logic was_clipped, saturated, last_out;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // register shadow
  logic [DECAY_W-1:0] m_decay = DECAY_RST;
  logic [CFG_W-1:0]   m_lr = LR_RST;
  logic [CFG_W-1:0]   m_eps = EPS_RST;
  logic [CLIP_W-1:0]  m_clip = CLIP_RST;
  logic [CFG_W-1:0]   m_wdecay = WDECAY_RST;

  req_t pending_reqs[$];
  upd_t expected_upds[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_clipped = 0;
  int n_sat = 0;
  bit steady = 0;
  bit held_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  rmsprop_weight_update dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .grad_in(grad_in), .weight_in(weight_in), .avg_in(avg_in), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .weight_out(weight_out), .avg_out(avg_out), .was_clipped(was_clipped),
    .saturated(saturated), .last_out(last_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [127:0] int_sqrt(input logic [127:0] x);
    logic [127:0] r, t;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // rmsprop step for one request under the shadow registers
  function automatic upd_t rmsprop_step(input req_t q);
    upd_t u;
    longint g, w, c, gc;
    logic [127:0] gm, wm, gcm, sq, acc, anew, root, den, stepm, regm;
    logic signed [127:0] wn;
    g = longint'(q.grad);
    w = longint'(q.weight);
    gm = (g < 0) ? 128'(-g) : 128'(g);
    wm = (w < 0) ? 128'(-w) : 128'(w);
    u.sat = 1'b0;
    u.clipped = 1'b0;
    u.last = q.last;
    // squared-gradient mean, unclipped gradient
    sq = (gm * gm + (128'd1 << 23)) >> 24;
    acc = 128'(q.avg) * 128'(m_decay) + sq * (128'd65536 - 128'(m_decay));
    anew = (acc + 128'd32768) >> 16;
    if (anew > 128'hFFFF_FFFF) begin
      u.avg = '1;
      u.sat = 1'b1;
    end else begin
      u.avg = anew[31:0];
    end
    // clip
    c = longint'(m_clip);
    gc = g;
    if (g > c) begin
      gc = c;
      u.clipped = 1'b1;
    end else if (g < -c) begin
      gc = -c;
      u.clipped = 1'b1;
    end
    gcm = (gc < 0) ? 128'(-gc) : 128'(gc);
    // step over the root; zero root means no step
    root = int_sqrt((anew + 128'(m_eps)) << 24);
    stepm = '0;
    if (root != 0) begin
      den = root << 8;
      stepm = (128'(m_lr) * gcm + (den >> 1)) / den;
    end
    regm = (128'(m_wdecay) * wm + (128'd1 << 31)) >> 32;
    wn = 128'(w);
    wn = (gc < 0) ? wn + $signed(stepm) : wn - $signed(stepm);
    wn = (w < 0) ? wn + $signed(regm) : wn - $signed(regm);
    if (wn > 128'sd2147483647) begin
      u.weight = 32'h7FFF_FFFF;
      u.sat = 1'b1;
    end else if (wn < -128'sd2147483648) begin
      u.weight = 32'h8000_0000;
      u.sat = 1'b1;
    end else begin
      u.weight = wn[31:0];
    end
    return u;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_upds = {expected_upds, rmsprop_step(pending_reqs.pop_front())};
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 18)) begin
        in_valid <= 1'b1;
        grad_in <= pending_reqs[0].grad;
        weight_in <= pending_reqs[0].weight;
        avg_in <= pending_reqs[0].avg;
        last_in <= pending_reqs[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    upd_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (expected_upds.size() == 0) begin
          $error("unexpected result weight_out=%0d", weight_out);
          errors++;
        end else begin
          e = expected_upds.pop_front();
          if (weight_out !== e.weight) begin
            $error("weight_out expected %0d got %0d", e.weight, weight_out);
            errors++;
          end
          if (avg_out !== e.avg) begin
            $error("avg_out expected %0d got %0d", e.avg, avg_out);
            errors++;
          end
          if (was_clipped !== e.clipped) begin
            $error("was_clipped expected %0b got %0b", e.clipped, was_clipped);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0b got %0b", e.sat, saturated);
            errors++;
          end
          if (last_out !== e.last) begin
            $error("last_out expected %0b got %0b", e.last, last_out);
            errors++;
          end
          n_clipped += e.clipped;
          n_sat += e.sat;
        end
      end
      // one long hold-off so the pipeline fills and stalls its input
      if (!held_done && n_recv == 200) begin
        held_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 18);
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DECAY: m_decay = val[DECAY_W-1:0];
      REG_LR: m_lr = val;
      REG_EPS: m_eps = val;
      REG_CLIP: m_clip = val[CLIP_W-1:0];
      REG_WDECAY: m_wdecay = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_req(input logic [31:0] g, input logic [31:0] w,
                         input logic [31:0] a, input logic l);
    req_t q;
    q.grad = g;
    q.weight = w;
    q.avg = a;
    q.last = l;
    pending_reqs = {pending_reqs, q};
  endtask

  // random field with a bias towards extremes and small magnitudes
  function automatic logic [31:0] pick_field();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(2 ** 25);
      3: return -$urandom_range(2 ** 25);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_upds.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, clipping both ways, signs, last flag
    add_req(32'd0, 32'd0, 32'd0, 1'b0);
    add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_req(32'd83886081, 32'd16777216, 32'd0, 1'b0);
    add_req(-32'd83886081, -32'd16777216, 32'd1, 1'b1);
    add_req(32'd83886080, 32'd1, 32'd16777216, 1'b0);
    add_req(-32'd83886080, -32'd1, 32'd16777216, 1'b0);
    add_req(32'd1, 32'hFFFF_FFFF, 32'd2, 1'b1);
    add_req(32'hFFFF_FFFF, 32'd5, 32'h8000_0000, 1'b0);
    add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    add_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    wait_drained();

    // zero smoothing and zero root; zero clip limit; unknown index ignored
    reg_write(REG_EPS, 32'd0);
    reg_write(REG_CLIP, 32'd0);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    add_req(32'd0, 32'd1000, 32'd0, 1'b0);
    add_req(32'd0, -32'd1000, 32'd0, 1'b1);
    add_req(32'd7, 32'd3, 32'd0, 1'b0);
    add_req(-32'd7, 32'd3, 32'd100, 1'b0);
    add_req(32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1);
    wait_drained();

    // random phases under a range of register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_DECAY, 32'd0);
          reg_write(REG_LR, 32'hFFFF_FFFF);
          reg_write(REG_EPS, 32'd0);
          reg_write(REG_CLIP, 32'h7FFF_FFFF);
          reg_write(REG_WDECAY, 32'hFFFF_FFFF);
        end
        1: begin
          reg_write(REG_DECAY, 32'h0000_FFFF);
          reg_write(REG_LR, 32'd0);
          reg_write(REG_EPS, 32'hFFFF_FFFF);
          reg_write(REG_CLIP, 32'd0);
          reg_write(REG_WDECAY, 32'd0);
        end
        2: begin
          reg_write(REG_DECAY, CFG_W'(DECAY_RST));
          reg_write(REG_LR, LR_RST);
          reg_write(REG_EPS, EPS_RST);
          reg_write(REG_CLIP, CFG_W'(CLIP_RST));
          reg_write(REG_WDECAY, WDECAY_RST);
        end
        default: begin
          reg_write(REG_DECAY, $urandom);
          reg_write(REG_LR, $urandom_range(1) ? $urandom : $urandom_range(2 ** 24));
          reg_write(REG_EPS, $urandom_range(1) ? $urandom : $urandom_range(16));
          reg_write(REG_CLIP, $urandom);
          reg_write(REG_WDECAY, $urandom);
        end
      endcase
      steady = (ph == 5);
      for (int i = 0; i < 85; i++)
        add_req(pick_field(), pick_field(), pick_field(), 1'($urandom_range(1)));
      wait_drained();
    end
    steady = 0;

    $display("covered %0d requests and %0d results, %0d clipped, %0d saturated",
             n_sent, n_recv, n_clipped, n_sat);
    $display("register settings spanned zero and full-scale values on every register");
    if (errors == 0 && expected_upds.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
